// ----- rtl/tic_pkg.sv -----
package tic_pkg;

  localparam int unsigned SEC_W  = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned TSEL_W = 4;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned IDX_W  = 1;

  localparam logic [MODE_W-1:0] MODE_LOCKED    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TIMING    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNLOCKED  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RELOCKING = 2'd3;

  localparam logic [IDX_W-1:0] REG_TIME_SELECT  = 1'd0;
  localparam logic [IDX_W-1:0] REG_INVERT_INPUT = 1'd1;

  localparam logic [SEC_W-1:0] RELOCK_SECS = 8'd1;

  function automatic logic [SEC_W-1:0] delay_secs(input logic [TSEL_W-1:0] sel);
    logic [SEC_W-1:0] secs;
    case (sel)
      4'd0:    secs = 8'd5;
      4'd1:    secs = 8'd10;
      4'd2:    secs = 8'd15;
      4'd3:    secs = 8'd20;
      4'd4:    secs = 8'd25;
      4'd5:    secs = 8'd30;
      4'd6:    secs = 8'd35;
      4'd7:    secs = 8'd40;
      4'd8:    secs = 8'd45;
      4'd9:    secs = 8'd50;
      4'd10:   secs = 8'd55;
      4'd11:   secs = 8'd60;
      4'd12:   secs = 8'd90;
      4'd13:   secs = 8'd120;
      4'd14:   secs = 8'd180;
      default: secs = 8'd5;
    endcase
    return secs;
  endfunction

endpackage

// ----- rtl/tic_poll_if.sv -----
interface tic_poll_if;
  logic valid;
  logic ready;
  logic half_second_tick;
  logic unlock_switch;
  logic control_input;

  modport source (output valid, output half_second_tick, output unlock_switch,
                  output control_input, input ready);
  modport sink (input valid, input half_second_tick, input unlock_switch,
                input control_input, output ready);
endinterface

// ----- rtl/tic_result_if.sv -----
interface tic_result_if import tic_pkg::*;;
  logic              valid;
  logic              ready;
  logic              turnout_diverging;
  logic              track_shunt;
  logic              lock_lamp;
  logic [MODE_W-1:0] mode;
  logic [SEC_W-1:0]  seconds_left;

  modport source (output valid, output turnout_diverging, output track_shunt,
                  output lock_lamp, output mode, output seconds_left, input ready);
  modport sink (input valid, input turnout_diverging, input track_shunt,
                input lock_lamp, input mode, input seconds_left, output ready);
endinterface

// ----- rtl/timelock_interlock_controller_core.sv -----
// An accepted poll's result is loaded into the result register on the edge that accepts it.
// Throughput: one poll per cycle; the single result register refills on the
// same edge it is taken, so input stalls only while a result waits unread.
// Reset (rst, synchronous, active high): locked mode, countdown 0, phase 1,
// all latches clear, configuration registers 0, result register empty.
module timelock_interlock_controller_core import tic_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  tic_poll_if.sink         poll,
  tic_result_if.source     result
);

  logic [TSEL_W-1:0] time_select;
  logic              invert_input;

  logic [MODE_W-1:0] lock_mode, lock_mode_next;
  logic [SEC_W-1:0]  countdown, countdown_next;
  logic              tick_phase, tick_phase_next;
  logic              turnout_latch, turnout_latch_next;
  logic              shunt_latch, shunt_latch_next;
  logic              lamp_latch, lamp_latch_next;

  logic              out_valid;
  logic              accept;
  logic              pos;
  logic [SEC_W-1:0]  cnt_ticked;

  assign poll.ready = !out_valid || result.ready;
  assign accept     = poll.valid && poll.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_select  <= '0;
      invert_input <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_SELECT:  time_select  <= cfg_data[TSEL_W-1:0];
        REG_INVERT_INPUT: invert_input <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_phase_next    = poll.half_second_tick ? ~tick_phase : tick_phase;
    cnt_ticked         = countdown;
    if (poll.half_second_tick && tick_phase_next && (countdown != '0)) begin
      cnt_ticked = countdown - 1'b1;
    end
    countdown_next     = cnt_ticked;
    lock_mode_next     = lock_mode;
    turnout_latch_next = turnout_latch;
    shunt_latch_next   = shunt_latch;
    lamp_latch_next    = lamp_latch;
    pos                = poll.control_input ^ invert_input;
    case (lock_mode)
      MODE_LOCKED: begin
        countdown_next     = '0;
        turnout_latch_next = 1'b0;
        shunt_latch_next   = 1'b0;
        lamp_latch_next    = 1'b0;
        if (poll.unlock_switch) begin
          countdown_next  = delay_secs(time_select);
          tick_phase_next = 1'b1;
          lock_mode_next  = MODE_TIMING;
        end
      end
      MODE_TIMING: begin
        turnout_latch_next = 1'b0;
        shunt_latch_next   = 1'b1;
        lamp_latch_next    = tick_phase_next;
        if (cnt_ticked == '0) begin
          lock_mode_next = poll.unlock_switch ? MODE_UNLOCKED : MODE_LOCKED;
        end
      end
      MODE_UNLOCKED: begin
        shunt_latch_next   = 1'b1;
        lamp_latch_next    = 1'b1;
        turnout_latch_next = pos;
        if (!poll.unlock_switch && !pos) begin
          countdown_next  = RELOCK_SECS;
          tick_phase_next = 1'b1;
          lock_mode_next  = MODE_RELOCKING;
        end
      end
      default: begin
        if (cnt_ticked == '0) begin
          lock_mode_next = poll.unlock_switch ? MODE_UNLOCKED : MODE_LOCKED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_mode     <= MODE_LOCKED;
      countdown     <= '0;
      tick_phase    <= 1'b1;
      turnout_latch <= 1'b0;
      shunt_latch   <= 1'b0;
      lamp_latch    <= 1'b0;
    end else if (accept) begin
      lock_mode     <= lock_mode_next;
      countdown     <= countdown_next;
      tick_phase    <= tick_phase_next;
      turnout_latch <= turnout_latch_next;
      shunt_latch   <= shunt_latch_next;
      lamp_latch    <= lamp_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.turnout_diverging <= turnout_latch_next;
      result.track_shunt       <= shunt_latch_next;
      result.lock_lamp         <= lamp_latch_next;
      result.mode              <= lock_mode_next;
      result.seconds_left      <= countdown_next;
    end
  end

  assign result.valid = out_valid;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted poll produced no result");

  a_empty_means_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> poll.ready)
    else $error("poll stalled with empty result register");

  a_timing_turnout_normal: assert property (@(posedge clk) disable iff (rst)
    (lock_mode == MODE_TIMING || lock_mode == MODE_RELOCKING) |-> !turnout_latch)
    else $error("turnout diverging while timing or relocking");

  a_countdown_range: assert property (@(posedge clk) disable iff (rst)
    countdown <= 8'd180)
    else $error("countdown out of range");

  a_locked_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && lock_mode == MODE_LOCKED && !poll.unlock_switch)
      |=> (countdown == '0 && !shunt_latch && !lamp_latch))
    else $error("locked mode did not clear state");

endmodule
